@@ design/mmsp_pkg.sv @@
// Package for the music macro string parser: byte codes, command and skip codes,
// controller/datapath command and status words, small lookup functions.
// No dependencies.
package mmsp_pkg;

   // byte codes
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_A     = 8'h41;
   localparam logic [7:0] CH_B     = 8'h42;
   localparam logic [7:0] CH_C     = 8'h43;
   localparam logic [7:0] CH_D     = 8'h44;
   localparam logic [7:0] CH_E     = 8'h45;
   localparam logic [7:0] CH_F     = 8'h46;
   localparam logic [7:0] CH_G     = 8'h47;
   localparam logic [7:0] CH_L     = 8'h4C;
   localparam logic [7:0] CH_M     = 8'h4D;
   localparam logic [7:0] CH_N     = 8'h4E;
   localparam logic [7:0] CH_O     = 8'h4F;
   localparam logic [7:0] CH_P     = 8'h50;
   localparam logic [7:0] CH_T     = 8'h54;
   localparam logic [7:0] CH_V     = 8'h56;
   localparam logic [7:0] CH_X     = 8'h58;

   // pending token
   localparam logic [2:0] CMD_NONE = 3'd0;
   localparam logic [2:0] CMD_O    = 3'd1;
   localparam logic [2:0] CMD_L    = 3'd2;
   localparam logic [2:0] CMD_P    = 3'd3;
   localparam logic [2:0] CMD_T    = 3'd4;
   localparam logic [2:0] CMD_N    = 3'd5;
   localparam logic [2:0] CMD_V    = 3'd6;
   localparam logic [2:0] CMD_NOTE = 3'd7;

   localparam logic [1:0] SKIP_NONE = 2'd0;
   localparam logic [1:0] SKIP_ONE  = 2'd1;
   localparam logic [1:0] SKIP_SEMI = 2'd2;

   // what follows token completion
   localparam logic [1:0] POST_SWITCH = 2'd0;
   localparam logic [1:0] POST_SEMI   = 2'd1;
   localparam logic [1:0] POST_RESET  = 2'd2;

   // divider operand select
   localparam logic [1:0] DSEL_CONST = 2'd0;
   localparam logic [1:0] DSEL_EMIT  = 2'd1;

   // register indexes
   localparam logic CSR_GLOBAL_VOLUME = 1'b0;
   localparam logic CSR_RETARD        = 1'b1;

   // divider geometry: quotient always fits 15 bits for every use here
   localparam int DIV_Q_BITS = 15;
   localparam int DIV_N_BITS = 30;
   localparam int DIV_D_BITS = 18;
   localparam int DIV_S_BITS = DIV_D_BITS + DIV_Q_BITS - 1;

   localparam logic [DIV_N_BITS-1:0] WHOLE_MS   = 30'd2000;
   localparam logic [DIV_N_BITS-1:0] TICK_SCALE = 30'd15360;
   localparam logic [DIV_D_BITS-1:0] MS_SCALE   = 18'd1000;

   // x/50 as (x*RET_RECIP) >> RET_SHIFT, exact for x below 2^21
   localparam logic [21:0] RET_RECIP = 22'd2684355;
   localparam int          RET_SHIFT = 27;

   typedef struct packed {
      logic       load;
      logic       dec;
      logic       cdone;
      logic       post;
      logic       div_start;
      logic [1:0] div_sel;
      logic       rmul;
      logic       out_load;
   } mmsp_cmd_type;

   typedef struct packed {
      logic imm;
      logic fin_cdiv;
      logic emit_pend;
      logic div_busy;
   } mmsp_status_type;

   // (x+2)/3 for a volume 0..9
   function automatic logic [1:0] vol_third(input logic [3:0] x);
      logic [1:0] r;
      case (x)
         4'd0:                r = 2'd0;
         4'd1, 4'd2, 4'd3:    r = 2'd1;
         4'd4, 4'd5, 4'd6:    r = 2'd2;
         default:             r = 2'd3;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] vol_code(input logic [3:0] idx);
      logic [1:0] r;
      case (idx)
         4'd4, 4'd5:          r = 2'd1;
         4'd6, 4'd8, 4'd9:    r = 2'd2;
         4'd0, 4'd1, 4'd2, 4'd3: r = 2'd0;
         default:             r = 2'd3;
      endcase
      return r;
   endfunction

   function automatic logic [3:0] letter_semi(input logic [7:0] b);
      logic [3:0] r;
      case (b)
         CH_A:    r = 4'd10;
         CH_B:    r = 4'd12;
         CH_C:    r = 4'd1;
         CH_D:    r = 4'd3;
         CH_E:    r = 4'd5;
         CH_F:    r = 4'd6;
         CH_G:    r = 4'd8;
         default: r = 4'd0;
      endcase
      return r;
   endfunction

endpackage

@@ design/mmsp_div.sv @@
// Restoring divider, one quotient bit per cycle, fixed quotient width.
// Depends on mmsp_pkg.
module mmsp_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [mmsp_pkg::DIV_N_BITS-1:0] dividend,
   input  logic [mmsp_pkg::DIV_D_BITS-1:0] divisor,
   output logic                            busy,
   output logic [mmsp_pkg::DIV_Q_BITS-1:0] quotient
);

   logic [mmsp_pkg::DIV_N_BITS-1:0] rem_ff, rem_in;
   logic [mmsp_pkg::DIV_S_BITS-1:0] dsr_ff, dsr_in;
   logic [mmsp_pkg::DIV_Q_BITS-1:0] quo_ff, quo_in;
   logic [3:0]                      cnt_ff, cnt_in;
   logic [mmsp_pkg::DIV_S_BITS:0]   diff;
   logic                            ge;

   always_comb begin
      diff = {1'b0, mmsp_pkg::DIV_S_BITS'(rem_ff)} - {1'b0, dsr_ff};
      ge   = !diff[mmsp_pkg::DIV_S_BITS];
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      if (start) begin
         rem_in = dividend;
         dsr_in = {divisor, (mmsp_pkg::DIV_Q_BITS-1)'(0)};
         quo_in = '0;
         cnt_in = 4'(mmsp_pkg::DIV_Q_BITS);
      end else if (cnt_ff != 4'd0) begin
         if (ge) begin
            rem_in = diff[mmsp_pkg::DIV_N_BITS-1:0];
         end
         quo_in = {quo_ff[mmsp_pkg::DIV_Q_BITS-2:0], ge};
         dsr_in = dsr_ff >> 1;
         cnt_in = cnt_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
      if (reset) begin
         cnt_ff <= 4'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign busy     = (cnt_ff != 4'd0);
   assign quotient = quo_ff;

endmodule

@@ design/mmsp_datapath.sv @@
// Parser datapath: string state, config registers, token completion, duration math.
// Depends on mmsp_pkg and mmsp_div.
module mmsp_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  mmsp_pkg::mmsp_cmd_type     cmd,
   output mmsp_pkg::mmsp_status_type  status,
   input  logic [7:0]                 req_character,
   input  logic                       csr_valid,
   input  logic                       csr_index,
   input  logic [6:0]                 csr_data,
   output logic [6:0]                 rsp_note_index,
   output logic [15:0]                rsp_duration_ticks,
   output logic [1:0]                 rsp_volume_code,
   output logic                       rsp_index_clamped
);

   logic [7:0]  chr_ff, chr_in;
   logic [3:0]  gvol_ff, gvol_in;
   logic [6:0]  retard_ff, retard_in;
   logic [7:0]  tempo_ff, tempo_in;
   logic [10:0] base_ff, base_in;
   logic [2:0]  oct_ff, oct_in;
   logic [3:0]  lvol_ff, lvol_in;
   logic [2:0]  pend_ff, pend_in;
   logic        first_ff, first_in;
   logic [9:0]  accum_ff, accum_in;
   logic [1:0]  skip_ff, skip_in;
   logic [3:0]  semi_ff, semi_in;
   logic [15:0] plen_ff, plen_in;
   logic [1:0]  post_ff, post_in;
   logic        cdivp_ff, cdivp_in;
   logic [6:0]  cv_ff, cv_in;
   logic        epend_ff, epend_in;
   logic [6:0]  ekey_ff, ekey_in;
   logic        eclamp_ff, eclamp_in;
   logic [1:0]  evc_ff, evc_in;
   logic [15:0] elen_ff, elen_in;
   logic [7:0]  etempo_ff, etempo_in;
   logic [14:0] d_ff, d_in;
   logic        pneg_ff, pneg_in;
   logic [20:0] pmag_ff, pmag_in;
   logic [6:0]  onote_ff, onote_in;
   logic [15:0] odur_ff, odur_in;
   logic [1:0]  ovc_ff, ovc_in;
   logic        oclamp_ff, oclamp_in;

   logic        num_pend, is_digit, imm, fin_en, use_min, dec_fin;
   logic [1:0]  post_kind;
   logic [9:0]  vraw, vlo, vhi, vcl;
   logic [6:0]  note_key, key_raw;
   logic [3:0]  gclamp, evol;
   logic [13:0] acc_mul;
   logic [17:0] dot_sum;
   logic [16:0] dot_half;
   logic signed [6:0]  rclamp;
   logic signed [22:0] prod;
   logic [22:0] pabs;
   logic [42:0] ret_prod;
   logic [14:0] ret_q;
   logic [17:0] dsum;

   logic                                div_busy;
   logic [mmsp_pkg::DIV_Q_BITS-1:0]     div_q;
   logic [mmsp_pkg::DIV_N_BITS-1:0]     div_n;
   logic [mmsp_pkg::DIV_D_BITS-1:0]     div_d;

   mmsp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_n),
      .divisor  (div_d),
      .busy     (div_busy),
      .quotient (div_q)
   );

   always_comb begin
      case (cmd.div_sel)
         mmsp_pkg::DSEL_EMIT: begin
            div_n = mmsp_pkg::DIV_N_BITS'(elen_ff) * mmsp_pkg::TICK_SCALE;
            div_d = mmsp_pkg::DIV_D_BITS'(etempo_ff) * mmsp_pkg::MS_SCALE;
         end
         default: begin
            div_n = mmsp_pkg::WHOLE_MS;
            div_d = mmsp_pkg::DIV_D_BITS'(cv_ff);
         end
      endcase
   end

   // byte classification against the current token state
   assign num_pend = (pend_ff >= mmsp_pkg::CMD_O) && (pend_ff <= mmsp_pkg::CMD_V);
   assign is_digit = (chr_ff >= mmsp_pkg::CH_ZERO) && (chr_ff <= mmsp_pkg::CH_NINE);

   always_comb begin
      imm       = 1'b0;
      fin_en    = 1'b1;
      use_min   = 1'b0;
      post_kind = mmsp_pkg::POST_SWITCH;
      if (chr_ff == mmsp_pkg::CH_NUL) begin
         fin_en    = (skip_ff == mmsp_pkg::SKIP_NONE);
         post_kind = mmsp_pkg::POST_RESET;
      end else if (skip_ff != mmsp_pkg::SKIP_NONE) begin
         imm = 1'b1;
      end else if (num_pend) begin
         if (first_ff && chr_ff == mmsp_pkg::CH_EQ) begin
            use_min   = 1'b1;
            post_kind = mmsp_pkg::POST_SEMI;
         end else if (is_digit) begin
            imm = 1'b1;
         end
      end else if (pend_ff == mmsp_pkg::CMD_NOTE) begin
         if (first_ff && (chr_ff == mmsp_pkg::CH_HASH || chr_ff == mmsp_pkg::CH_PLUS ||
                          chr_ff == mmsp_pkg::CH_MINUS)) begin
            imm = 1'b1;
         end else if (chr_ff == mmsp_pkg::CH_DOT) begin
            imm = 1'b1;
         end
      end
   end

   assign dec_fin = !imm && fin_en;

   // number clamp per command
   always_comb begin
      vraw = use_min ? 10'd0 : accum_ff;
      case (pend_ff)
         mmsp_pkg::CMD_O: begin vlo = 10'd0;  vhi = 10'd6;   end
         mmsp_pkg::CMD_L,
         mmsp_pkg::CMD_P: begin vlo = 10'd1;  vhi = 10'd64;  end
         mmsp_pkg::CMD_T: begin vlo = 10'd32; vhi = 10'd255; end
         mmsp_pkg::CMD_N: begin vlo = 10'd0;  vhi = 10'd84;  end
         default:         begin vlo = 10'd0;  vhi = 10'd9;   end
      endcase
      if (vraw < vlo) begin
         vcl = vlo;
      end else if (vraw > vhi) begin
         vcl = vhi;
      end else begin
         vcl = vraw;
      end
   end

   always_comb begin
      note_key = 7'(semi_ff) + 7'(oct_ff) * 7'd12;
      key_raw  = (pend_ff == mmsp_pkg::CMD_N) ? vcl[6:0] : note_key;
      gclamp   = (gvol_ff > 4'd9) ? 4'd9 : gvol_ff;
      evol     = (pend_ff == mmsp_pkg::CMD_P) ? 4'd0 : ((lvol_ff > 4'd9) ? 4'd9 : lvol_ff);
      acc_mul  = 14'(accum_ff) * 14'd10 + 14'(chr_ff - mmsp_pkg::CH_ZERO);
      dot_sum  = 18'(plen_ff) + {1'b0, plen_ff, 1'b0};
      dot_half = dot_sum[17:1];
      if ($signed(retard_ff) < -7'sd30) begin
         rclamp = -7'sd30;
      end else if ($signed(retard_ff) > 7'sd40) begin
         rclamp = 7'sd40;
      end else begin
         rclamp = $signed(retard_ff);
      end
      prod = $signed({1'b0, div_q}) * rclamp;
      pabs = prod[22] ? 23'(-prod) : 23'(prod);
      ret_prod = 43'(pmag_ff) * 43'(mmsp_pkg::RET_RECIP);
      ret_q    = 15'(ret_prod >> mmsp_pkg::RET_SHIFT);
      dsum = pneg_ff ? (18'(d_ff) - 18'(ret_q)) : (18'(d_ff) + 18'(ret_q));
   end

   always_comb begin
      chr_in    = cmd.load ? req_character : chr_ff;
      gvol_in   = gvol_ff;
      retard_in = retard_ff;
      tempo_in  = tempo_ff;
      base_in   = base_ff;
      oct_in    = oct_ff;
      lvol_in   = lvol_ff;
      pend_in   = pend_ff;
      first_in  = first_ff;
      accum_in  = accum_ff;
      skip_in   = skip_ff;
      semi_in   = semi_ff;
      plen_in   = plen_ff;
      post_in   = post_ff;
      cdivp_in  = cdivp_ff;
      cv_in     = cv_ff;
      epend_in  = epend_ff;
      ekey_in   = ekey_ff;
      eclamp_in = eclamp_ff;
      evc_in    = evc_ff;
      elen_in   = elen_ff;
      etempo_in = etempo_ff;
      d_in      = d_ff;
      pneg_in   = pneg_ff;
      pmag_in   = pmag_ff;
      onote_in  = onote_ff;
      odur_in   = odur_ff;
      ovc_in    = ovc_ff;
      oclamp_in = oclamp_ff;

      if (csr_valid) begin
         case (csr_index)
            mmsp_pkg::CSR_GLOBAL_VOLUME: gvol_in   = csr_data[3:0];
            default:                     retard_in = csr_data;
         endcase
      end

      if (cmd.dec) begin
         post_in = post_kind;
         if (imm) begin
            if (skip_ff == mmsp_pkg::SKIP_ONE) begin
               skip_in = mmsp_pkg::SKIP_NONE;
            end else if (skip_ff == mmsp_pkg::SKIP_SEMI) begin
               if (chr_ff == mmsp_pkg::CH_SEMI) begin
                  skip_in = mmsp_pkg::SKIP_NONE;
               end
            end else if (num_pend) begin
               accum_in = (acc_mul > 14'd1023) ? 10'd1023 : acc_mul[9:0];
               first_in = 1'b0;
            end else begin
               if (chr_ff == mmsp_pkg::CH_DOT) begin
                  plen_in = dot_half[16] ? 16'hFFFF : dot_half[15:0];
               end else if (chr_ff == mmsp_pkg::CH_MINUS) begin
                  semi_in = semi_ff - 4'd1;
               end else begin
                  semi_in = semi_ff + 4'd1;
               end
               first_in = 1'b0;
            end
         end else if (fin_en) begin
            pend_in   = mmsp_pkg::CMD_NONE;
            first_in  = 1'b0;
            ekey_in   = (key_raw > 7'd84) ? 7'd84 : key_raw;
            eclamp_in = (key_raw > 7'd84);
            evc_in    = mmsp_pkg::vol_code({mmsp_pkg::vol_third(gclamp),
                                            mmsp_pkg::vol_third(evol)});
            etempo_in = tempo_ff;
            cv_in     = vcl[6:0];
            cdivp_in  = (pend_ff == mmsp_pkg::CMD_P);
            case (pend_ff)
               mmsp_pkg::CMD_O: oct_in   = vcl[2:0];
               mmsp_pkg::CMD_T: tempo_in = vcl[7:0];
               mmsp_pkg::CMD_V: lvol_in  = vcl[3:0];
               mmsp_pkg::CMD_P: begin
                  ekey_in   = 7'd0;
                  eclamp_in = 1'b0;
               end
               mmsp_pkg::CMD_N: begin
                  elen_in  = 16'(base_ff);
                  epend_in = 1'b1;
               end
               mmsp_pkg::CMD_NOTE: begin
                  elen_in  = plen_ff;
                  epend_in = 1'b1;
               end
               default: ;
            endcase
         end
      end

      if (cmd.cdone) begin
         if (cdivp_ff) begin
            elen_in  = 16'(div_q);
            epend_in = 1'b1;
         end else begin
            base_in = div_q[10:0];
         end
      end

      if (cmd.post) begin
         case (post_ff)
            mmsp_pkg::POST_RESET: begin
               tempo_in = 8'd120;
               base_in  = 11'd500;
               oct_in   = 3'd4;
               lvol_in  = 4'd3;
               pend_in  = mmsp_pkg::CMD_NONE;
               first_in = 1'b0;
               accum_in = 10'd0;
               skip_in  = mmsp_pkg::SKIP_NONE;
               semi_in  = 4'd0;
               plen_in  = 16'd0;
            end
            mmsp_pkg::POST_SEMI: skip_in = mmsp_pkg::SKIP_SEMI;
            default: begin
               case (chr_ff)
                  mmsp_pkg::CH_O, mmsp_pkg::CH_L, mmsp_pkg::CH_P,
                  mmsp_pkg::CH_T, mmsp_pkg::CH_N, mmsp_pkg::CH_V: begin
                     first_in = 1'b1;
                     accum_in = 10'd0;
                     case (chr_ff)
                        mmsp_pkg::CH_O: pend_in = mmsp_pkg::CMD_O;
                        mmsp_pkg::CH_L: pend_in = mmsp_pkg::CMD_L;
                        mmsp_pkg::CH_P: pend_in = mmsp_pkg::CMD_P;
                        mmsp_pkg::CH_T: pend_in = mmsp_pkg::CMD_T;
                        mmsp_pkg::CH_N: pend_in = mmsp_pkg::CMD_N;
                        default:        pend_in = mmsp_pkg::CMD_V;
                     endcase
                  end
                  mmsp_pkg::CH_GT: if (oct_ff < 3'd6) oct_in = oct_ff + 3'd1;
                  mmsp_pkg::CH_LT: if (oct_ff > 3'd0) oct_in = oct_ff - 3'd1;
                  mmsp_pkg::CH_M:  skip_in = mmsp_pkg::SKIP_ONE;
                  mmsp_pkg::CH_X:  skip_in = mmsp_pkg::SKIP_SEMI;
                  mmsp_pkg::CH_A, mmsp_pkg::CH_B, mmsp_pkg::CH_C, mmsp_pkg::CH_D,
                  mmsp_pkg::CH_E, mmsp_pkg::CH_F, mmsp_pkg::CH_G: begin
                     pend_in  = mmsp_pkg::CMD_NOTE;
                     semi_in  = mmsp_pkg::letter_semi(chr_ff);
                     plen_in  = 16'(base_ff);
                     first_in = 1'b1;
                  end
                  default: ;
               endcase
            end
         endcase
      end

      // retard term: product sign and magnitude, scaled by 1/50 at output
      if (cmd.rmul) begin
         d_in    = div_q;
         pneg_in = prod[22];
         pmag_in = pabs[20:0];
      end

      if (cmd.out_load) begin
         epend_in  = 1'b0;
         onote_in  = ekey_ff;
         oclamp_in = eclamp_ff;
         ovc_in    = evc_ff;
         if (dsum[17]) begin
            odur_in = 16'd0;
         end else if (dsum[16]) begin
            odur_in = 16'hFFFF;
         end else begin
            odur_in = dsum[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      chr_ff    <= chr_in;
      post_ff   <= post_in;
      cdivp_ff  <= cdivp_in;
      cv_ff     <= cv_in;
      ekey_ff   <= ekey_in;
      eclamp_ff <= eclamp_in;
      evc_ff    <= evc_in;
      elen_ff   <= elen_in;
      etempo_ff <= etempo_in;
      d_ff      <= d_in;
      pneg_ff   <= pneg_in;
      pmag_ff   <= pmag_in;
      onote_ff  <= onote_in;
      odur_ff   <= odur_in;
      ovc_ff    <= ovc_in;
      oclamp_ff <= oclamp_in;
      if (reset) begin
         gvol_ff   <= 4'd3;
         retard_ff <= 7'd0;
         tempo_ff  <= 8'd120;
         base_ff   <= 11'd500;
         oct_ff    <= 3'd4;
         lvol_ff   <= 4'd3;
         pend_ff   <= mmsp_pkg::CMD_NONE;
         first_ff  <= 1'b0;
         accum_ff  <= 10'd0;
         skip_ff   <= mmsp_pkg::SKIP_NONE;
         semi_ff   <= 4'd0;
         plen_ff   <= 16'd0;
         epend_ff  <= 1'b0;
      end else begin
         gvol_ff   <= gvol_in;
         retard_ff <= retard_in;
         tempo_ff  <= tempo_in;
         base_ff   <= base_in;
         oct_ff    <= oct_in;
         lvol_ff   <= lvol_in;
         pend_ff   <= pend_in;
         first_ff  <= first_in;
         accum_ff  <= accum_in;
         skip_ff   <= skip_in;
         semi_ff   <= semi_in;
         plen_ff   <= plen_in;
         epend_ff  <= epend_in;
      end
   end

   assign status.imm       = imm;
   assign status.fin_cdiv  = dec_fin && (pend_ff == mmsp_pkg::CMD_L || pend_ff == mmsp_pkg::CMD_P);
   assign status.emit_pend = epend_ff;
   assign status.div_busy  = div_busy;

   assign rsp_note_index     = onote_ff;
   assign rsp_duration_ticks = odur_ff;
   assign rsp_volume_code    = ovc_ff;
   assign rsp_index_clamped  = oclamp_ff;

endmodule

@@ design/mmsp_ctrl.sv @@
// Parser controller: sequences decode, token completion, divider passes and output.
// Depends on mmsp_pkg.
module mmsp_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  mmsp_pkg::mmsp_status_type  status,
   output mmsp_pkg::mmsp_cmd_type     cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DEC    = 4'd1;
   localparam logic [3:0] S_C_GO   = 4'd2;
   localparam logic [3:0] S_C_WAIT = 4'd3;
   localparam logic [3:0] S_POST   = 4'd4;
   localparam logic [3:0] S_E_GO   = 4'd5;
   localparam logic [3:0] S_E_WAIT = 4'd6;
   localparam logic [3:0] S_OUT    = 4'd7;

   logic [3:0] state_ff, state_in;
   logic       rvalid_ff, rvalid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.div_sel = mmsp_pkg::DSEL_CONST;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            cmd.dec = 1'b1;
            if (status.imm) begin
               state_in = S_IDLE;
            end else if (status.fin_cdiv) begin
               state_in = S_C_GO;
            end else begin
               state_in = S_POST;
            end
         end
         S_C_GO: begin
            cmd.div_start = 1'b1;
            state_in = S_C_WAIT;
         end
         S_C_WAIT: begin
            if (!status.div_busy) begin
               cmd.cdone = 1'b1;
               state_in  = S_POST;
            end
         end
         S_POST: begin
            cmd.post = 1'b1;
            state_in = status.emit_pend ? S_E_GO : S_IDLE;
         end
         S_E_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = mmsp_pkg::DSEL_EMIT;
            state_in = S_E_WAIT;
         end
         S_E_WAIT: begin
            if (!status.div_busy) begin
               cmd.rmul = 1'b1;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rvalid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rvalid_in = 1'b1;
      end else if (rsp_ready) begin
         rvalid_in = 1'b0;
      end else begin
         rvalid_in = rvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rvalid_ff <= rvalid_in;
      end
   end

   assign rsp_valid = rvalid_ff;

endmodule

@@ design/music_macro_string_parser.sv @@
// Music macro string parser top level: controller plus datapath.
// Depends on mmsp_pkg, mmsp_ctrl, mmsp_datapath (which holds mmsp_div).
//
// Takes one byte of a music macro string per req word and returns one rsp word per
// note or rest (key index, duration in 1/128 s, volume code, clamp flag). Finishing
// an L or P adds a pass of the shared radix-2 divider (2000/n) with its start and
// hand-off. A note or rest then runs one more divider pass (length*15360 over
// tempo*1000), scales the retard term by 1/50 with a reciprocal multiply, and its
// rsp word is loaded into the output register. A finished word waits in the output
// register; the next byte is taken only after the current one is fully handled.
// csr_index 0 is global volume, 1 is retard; csr_ready is always high.
module music_macro_string_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_character,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [6:0]  rsp_note_index,
   output logic [15:0] rsp_duration_ticks,
   output logic [1:0]  rsp_volume_code,
   output logic        rsp_index_clamped,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [6:0]  csr_data
);

   mmsp_pkg::mmsp_cmd_type    cmd;
   mmsp_pkg::mmsp_status_type status;

   assign csr_ready = 1'b1;

   mmsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mmsp_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_character      (req_character),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_note_index     (rsp_note_index),
      .rsp_duration_ticks (rsp_duration_ticks),
      .rsp_volume_code    (rsp_volume_code),
      .rsp_index_clamped  (rsp_index_clamped)
   );

endmodule

@@ tb/sv/music_macro_string_parser_tb.sv @@
// Testbench for music_macro_string_parser: feeds music string bytes, predicts
// each note/rest word with a behavioral parser model and checks rsp words in order.
// Depends on mmsp_pkg and the design files.
module music_macro_string_parser_tb;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_character;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [6:0]  rsp_note_index;
   logic [15:0] rsp_duration_ticks;
   logic [1:0]  rsp_volume_code;
   logic        rsp_index_clamped;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [6:0]  csr_data;

   typedef struct packed {
      logic [6:0]  key;
      logic [15:0] ticks;
      logic [1:0]  vcode;
      logic        clamped;
   } note_word_type;

   typedef struct {
      logic [7:0]    ch;
      logic          has_exp;
      note_word_type exp_word;
   } dir_row_type;

   music_macro_string_parser i_dut (.*);

   // predictor state
   logic [3:0]  pv_gvol;
   logic [6:0]  pv_retard;
   logic [7:0]  pv_tempo;
   logic [15:0] pv_len;
   logic [2:0]  pv_oct;
   logic [3:0]  pv_lvol;
   logic [2:0]  pv_cmd;
   logic        pv_first;
   logic [15:0] pv_num;
   logic [1:0]  pv_skip;
   logic [3:0]  pv_semi;
   logic [15:0] pv_plen;

   note_word_type expected_notes[$];
   int            errors = 0;
   bit            stim_done = 0;

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   initial begin
      #50000000;
      $display("music_macro_string_parser verification failed");
      $finish;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [1:0] vol_lookup(int idx);
      case (idx)
         4, 5:    return 2'd1;
         6, 8, 9: return 2'd2;
         0, 1, 2, 3: return 2'd0;
         default: return 2'd3;
      endcase
   endfunction

   function automatic note_word_type make_note(int key, int len, int vol);
      note_word_type w;
      longint r, d;
      int g, t;
      r = pv_retard[6] ? int'(pv_retard) - 128 : int'(pv_retard);
      if (r < -30) r = -30;
      if (r > 40) r = 40;
      g = pv_gvol > 9 ? 9 : pv_gvol;
      t = pv_tempo == 0 ? 1 : pv_tempo;
      d = (longint'(len) * 15360 / t) / 1000;
      d = d + (d * r) / 50;
      if (d < 0) d = 0;
      if (d > 65535) d = 65535;
      w.clamped = key > 84;
      w.key = key > 84 ? 7'd84 : 7'(key);
      if (vol > 9) vol = 9;
      w.ticks = d[15:0];
      w.vcode = vol_lookup(4 * ((g + 2) / 3) + (vol + 2) / 3);
      return w;
   endfunction

   task automatic complete_token(bit use_min);
      int c, v, lo, hi;
      c = pv_cmd;
      pv_cmd = mmsp_pkg::CMD_NONE;
      pv_first = 0;
      if (c == mmsp_pkg::CMD_NOTE) begin
         expected_notes.push_back(make_note(pv_semi + 12 * pv_oct, pv_plen, pv_lvol));
         return;
      end
      if (c == mmsp_pkg::CMD_NONE) return;
      v = use_min ? 0 : pv_num;
      case (c)
         mmsp_pkg::CMD_O: begin lo = 0; hi = 6; end
         mmsp_pkg::CMD_L, mmsp_pkg::CMD_P: begin lo = 1; hi = 64; end
         mmsp_pkg::CMD_T: begin lo = 32; hi = 255; end
         mmsp_pkg::CMD_N: begin lo = 0; hi = 84; end
         default: begin lo = 0; hi = 9; end
      endcase
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      case (c)
         mmsp_pkg::CMD_O: pv_oct = 3'(v);
         mmsp_pkg::CMD_L: pv_len = 16'(2000 / v);
         mmsp_pkg::CMD_P: expected_notes.push_back(make_note(0, 2000 / v, 0));
         mmsp_pkg::CMD_T: pv_tempo = 8'(v);
         mmsp_pkg::CMD_N: expected_notes.push_back(make_note(v, pv_len, pv_lvol));
         default: pv_lvol = 4'(v);
      endcase
   endtask

   task automatic clear_locals();
      pv_tempo = 120; pv_len = 500; pv_oct = 4; pv_lvol = 3;
      pv_cmd = mmsp_pkg::CMD_NONE; pv_first = 0; pv_num = 0;
      pv_skip = mmsp_pkg::SKIP_NONE;
      pv_semi = 0; pv_plen = 0;
   endtask

   task automatic parse_byte(logic [7:0] b);
      int a;
      if (b == mmsp_pkg::CH_NUL) begin
         if (pv_skip == mmsp_pkg::SKIP_NONE) complete_token(0);
         clear_locals();
         return;
      end
      if (pv_skip == mmsp_pkg::SKIP_ONE) begin pv_skip = mmsp_pkg::SKIP_NONE; return; end
      if (pv_skip == mmsp_pkg::SKIP_SEMI) begin
         if (b == mmsp_pkg::CH_SEMI) pv_skip = mmsp_pkg::SKIP_NONE;
         return;
      end
      if (pv_cmd >= mmsp_pkg::CMD_O && pv_cmd <= mmsp_pkg::CMD_V) begin
         if (pv_first && b == mmsp_pkg::CH_EQ) begin
            complete_token(1);
            pv_skip = mmsp_pkg::SKIP_SEMI;
            return;
         end
         if (b >= mmsp_pkg::CH_ZERO && b <= mmsp_pkg::CH_NINE) begin
            a = pv_num * 10 + (b - mmsp_pkg::CH_ZERO);
            pv_num = 16'(a > 1023 ? 1023 : a);
            pv_first = 0;
            return;
         end
         complete_token(0);
      end else if (pv_cmd == mmsp_pkg::CMD_NOTE) begin
         if (pv_first && (b == mmsp_pkg::CH_HASH || b == mmsp_pkg::CH_PLUS)) begin
            pv_semi = pv_semi + 4'd1; pv_first = 0; return;
         end
         if (pv_first && b == mmsp_pkg::CH_MINUS) begin
            pv_semi = pv_semi - 4'd1; pv_first = 0; return;
         end
         if (b == mmsp_pkg::CH_DOT) begin
            a = pv_plen * 3 / 2;
            pv_plen = 16'(a > 65535 ? 65535 : a);
            pv_first = 0;
            return;
         end
         complete_token(0);
      end
      case (b)
         mmsp_pkg::CH_O: pv_cmd = mmsp_pkg::CMD_O;
         mmsp_pkg::CH_L: pv_cmd = mmsp_pkg::CMD_L;
         mmsp_pkg::CH_P: pv_cmd = mmsp_pkg::CMD_P;
         mmsp_pkg::CH_T: pv_cmd = mmsp_pkg::CMD_T;
         mmsp_pkg::CH_N: pv_cmd = mmsp_pkg::CMD_N;
         mmsp_pkg::CH_V: pv_cmd = mmsp_pkg::CMD_V;
         mmsp_pkg::CH_GT: begin if (pv_oct < 6) pv_oct++; return; end
         mmsp_pkg::CH_LT: begin if (pv_oct > 0) pv_oct--; return; end
         mmsp_pkg::CH_M: begin pv_skip = mmsp_pkg::SKIP_ONE; return; end
         mmsp_pkg::CH_X: begin pv_skip = mmsp_pkg::SKIP_SEMI; return; end
         default: begin
            if (b >= mmsp_pkg::CH_A && b <= mmsp_pkg::CH_G) begin
               pv_cmd = mmsp_pkg::CMD_NOTE;
               pv_semi = mmsp_pkg::letter_semi(b);
               pv_plen = pv_len;
               pv_first = 1;
            end
            return;
         end
      endcase
      pv_first = 1;
      pv_num = 0;
   endtask

   // valid stays up across a zero gap; dropped only when an idle gap follows
   task automatic send_byte(logic [7:0] b);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1;
      req_character <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      parse_byte(b);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic write_reg(logic idx, logic [6:0] val);
      req_valid <= 0;
      // let any byte still in flight finish before touching registers
      while (expected_notes.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      if (idx == mmsp_pkg::CSR_GLOBAL_VOLUME) pv_gvol = val[3:0];
      else pv_retard = val;
   endtask

   // result side: random stalls, compare against oldest prediction
   initial begin
      note_word_type got, want;
      int hold;
      rsp_ready = 0;
      hold = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_note_index, rsp_duration_ticks, rsp_volume_code, rsp_index_clamped};
            if (expected_notes.size() == 0) begin
               $display("%0t: exp no word got %h", $time, got);
               errors++;
            end else begin
               want = expected_notes.pop_front();
               if (got.key !== want.key)
                  $display("%0t: note_index exp %0d got %0d", $time, want.key, got.key);
               if (got.ticks !== want.ticks)
                  $display("%0t: duration exp %0d got %0d", $time, want.ticks, got.ticks);
               if (got.vcode !== want.vcode)
                  $display("%0t: volume exp %0d got %0d", $time, want.vcode, got.vcode);
               if (got.clamped !== want.clamped)
                  $display("%0t: clamped exp %0d got %0d", $time, want.clamped,
                           got.clamped);
               if (got !== want) errors++;
            end
            hold = gap_len();
         end
         if (hold > 0 && !stim_done) begin
            hold--;
            rsp_ready <= 0;
         end else begin
            rsp_ready <= 1;
         end
      end
   end

   // note letters, commands, digits, punctuation, NUL and random bytes used to build random strings
   function automatic logic [7:0] rand_token_byte();
      int r;
      string letters, cmds, marks, octs, skips;
      letters = "ABCDEFG";
      cmds    = "OLPTNV";
      marks   = "#+-.";
      octs    = "<>";
      skips   = "MX=;";
      r = $urandom_range(0, 99);
      if (r < 30) return letters[$urandom_range(0, 6)];
      if (r < 45) return cmds[$urandom_range(0, 5)];
      if (r < 65) return 8'(mmsp_pkg::CH_ZERO + $urandom_range(0, 9));
      if (r < 75) return marks[$urandom_range(0, 3)];
      if (r < 83) return octs[$urandom_range(0, 1)];
      if (r < 87) return skips[$urandom_range(0, 3)];
      if (r < 90) return mmsp_pkg::CH_NUL;
      return 8'($urandom_range(0, 255));
   endfunction

   dir_row_type dir_rows[$];

   initial begin
      note_word_type w;
      string clamp_text;
      reset = 1;
      req_valid = 0; req_character = 0;
      csr_valid = 0; csr_index = 0; csr_data = 0;
      pv_gvol = 3; pv_retard = 0;
      clear_locals();
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: rows with typed expectation at reset defaults
      w = '{7'd49, 16'd64, 2'd1, 1'b0};   // C at octave 4, 500 ms, tempo 120
      dir_rows.push_back('{mmsp_pkg::CH_C, 1'b0, w});
      dir_rows.push_back('{mmsp_pkg::CH_NUL, 1'b1, w});
      w = '{7'd84, 16'd64, 2'd1, 1'b1};   // B# in octave 6 clamps
      clamp_text = "O6B#";
      for (int i = 0; i < clamp_text.len(); i++)
         dir_rows.push_back('{clamp_text[i], 1'b0, w});
      dir_rows.push_back('{mmsp_pkg::CH_NUL, 1'b1, w});
      foreach (dir_rows[i]) begin
         send_byte(dir_rows[i].ch);
         if (dir_rows[i].has_exp) begin
            if (expected_notes.size() == 0) begin
               $display("%0t: table exp %h model none", $time, dir_rows[i].exp_word);
               errors++;
            end else if (expected_notes[$] !== dir_rows[i].exp_word) begin
               $display("%0t: table exp %h model %h", $time, dir_rows[i].exp_word,
                        expected_notes[$]);
               errors++;
            end
         end
      end
      send_text("O0C-P=;N=;O9999B.......L64D#T255E-V0F+G");
      send_byte(mmsp_pkg::CH_NUL);
      send_text("MAXAB;C<<<<<<<<>>>>>>>>>A.N85P1T32V9N0,abc ");
      send_byte(mmsp_pkg::CH_NUL);

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_reg(mmsp_pkg::CSR_GLOBAL_VOLUME, 0);
               write_reg(mmsp_pkg::CSR_RETARD, 7'h62);
            end
            1: begin
               write_reg(mmsp_pkg::CSR_GLOBAL_VOLUME, 9);
               write_reg(mmsp_pkg::CSR_RETARD, 7'd40);
            end
            2: begin
               write_reg(mmsp_pkg::CSR_GLOBAL_VOLUME, 15);
               write_reg(mmsp_pkg::CSR_RETARD, 7'h7F);
            end
            3: begin
               write_reg(mmsp_pkg::CSR_GLOBAL_VOLUME, 5);
               write_reg(mmsp_pkg::CSR_RETARD, 7'h40);
            end
            4: begin
               write_reg(mmsp_pkg::CSR_GLOBAL_VOLUME, 1);
               write_reg(mmsp_pkg::CSR_RETARD, 7'd63);
            end
            default: begin
               write_reg(mmsp_pkg::CSR_GLOBAL_VOLUME, 7'($urandom_range(0, 15)));
               write_reg(mmsp_pkg::CSR_RETARD, 7'($urandom_range(0, 127)));
            end
         endcase
         repeat (120) begin
            send_byte(rand_token_byte());
         end
      end
      send_byte(mmsp_pkg::CH_NUL);
      req_valid <= 0;
      stim_done = 1;
      while (expected_notes.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0 && expected_notes.size() == 0)
         $display("music_macro_string_parser verification clean");
      else
         $display("music_macro_string_parser verification failed");
      $finish;
   end
endmodule

@@ sim.f @@
design/mmsp_pkg.sv
design/mmsp_div.sv
design/mmsp_datapath.sv
design/mmsp_ctrl.sv
design/music_macro_string_parser.sv
tb/sv/music_macro_string_parser_tb.sv
